// ===== rtl/etw_pkg.sv =====
package etw_pkg;

    localparam int FRAC_BITS = 16;
    localparam longint ONE = longint'(1) <<< FRAC_BITS;

    localparam int POW_DEPTH = 256;
    localparam int POW_IDX_W = $clog2(POW_DEPTH);
    localparam int POW_W = FRAC_BITS + 1;
    localparam int POW_HALF = POW_DEPTH / 2;

    localparam int MUL_W = 24;
    localparam int PROD_W = 2 * MUL_W - FRAC_BITS + 1;

    typedef logic signed [MUL_W-1:0] mop_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    // back-curve constants, Q FRAC_BITS
    localparam longint C1 = ((longint'(170158) <<< FRAC_BITS) + 50000) / 100000;
    localparam longint C2 = ((longint'(259490950) <<< FRAC_BITS) + 50000000) / 100000000;
    localparam longint C3 = C1 + ONE;

    localparam logic [1:0] KIND_TICK    = 2'd0;
    localparam logic [1:0] KIND_RESTART = 2'd1;
    localparam logic [1:0] KIND_FINISH  = 2'd2;

    localparam logic [1:0] REG_START    = 2'd0;
    localparam logic [1:0] REG_END      = 2'd1;
    localparam logic [1:0] REG_DURATION = 2'd2;
    localparam logic [1:0] REG_MODE     = 2'd3;

    localparam logic [3:0] MODE_LINEAR       = 4'd0;
    localparam logic [3:0] MODE_IN_QUAD      = 4'd1;
    localparam logic [3:0] MODE_OUT_QUAD     = 4'd2;
    localparam logic [3:0] MODE_INOUT_QUAD   = 4'd3;
    localparam logic [3:0] MODE_IN_CUBIC     = 4'd4;
    localparam logic [3:0] MODE_OUT_CUBIC    = 4'd5;
    localparam logic [3:0] MODE_INOUT_CUBIC  = 4'd6;
    localparam logic [3:0] MODE_IN_EXPO      = 4'd7;
    localparam logic [3:0] MODE_OUT_EXPO     = 4'd8;
    localparam logic [3:0] MODE_INOUT_EXPO   = 4'd9;
    localparam logic [3:0] MODE_IN_BACK      = 4'd10;
    localparam logic [3:0] MODE_OUT_BACK     = 4'd11;
    localparam logic [3:0] MODE_INOUT_BACK   = 4'd12;

    // truncating divide of a non-negative value, compare and subtract
    function automatic longint div_small(input longint num, input longint den);
        longint q;
        longint r;
        q = 0;
        r = 0;
        for (int i = 62; i >= 0; i--) begin
            r = (r <<< 1) | ((num >>> i) & longint'(1));
            q = q <<< 1;
            if (r >= den) begin
                r = r - den;
                q = q | longint'(1);
            end
        end
        return q;
    endfunction

    // 2^(k/POW_DEPTH) in Q FRAC_BITS, from a Q30 series
    function automatic logic [POW_W*POW_DEPTH-1:0] pow_table_build();
        logic [POW_W*POW_DEPTH-1:0] tbl;
        longint x;
        longint term;
        longint sum;
        tbl = '0;
        for (int k = 0; k < POW_DEPTH; k++) begin
            x = (longint'(744261118) * longint'(k) + longint'(POW_HALF)) >>> POW_IDX_W;
            term = longint'(1) <<< 30;
            sum = term;
            for (int n = 1; n <= 20; n++) begin
                term = div_small((term * x) >>> 30, longint'(n));
                sum = sum + term;
            end
            tbl[k*POW_W +: POW_W] =
                POW_W'((sum + (longint'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS));
        end
        return tbl;
    endfunction

    localparam logic [POW_W*POW_DEPTH-1:0] POW_TABLE = pow_table_build();

    function automatic logic [POW_W-1:0] pow_entry(input logic [POW_IDX_W-1:0] k);
        return POW_TABLE[k*POW_W +: POW_W];
    endfunction

endpackage

// ===== rtl/eased_tween_interpolator.sv =====
// Eased tween interpolator.
// Configuration: cfg_wr_en writes cfg_wr_data into register cfg_addr
// (0 start value, 1 end value, 2 duration in ticks, 3 ease mode).
// Write only while the block is idle.
// Input channel s_*: one word per command (tick with delta, restart,
// finish). Result channel m_*: one word per command with the level,
// the linear progress in Q1.16 and the complete flag.
// Sequence: the count is updated when a word is accepted, then the
// bit-serial progress divide runs unless the tween is complete; then, for
// a tick that moves the tween, the curve and the level are computed on the
// one bit-serial multiplier: 1 multiply for linear, 2 for quad and expo,
// 3 for cubic, 4 for in-out back, 5 for in and out back; then the result
// goes into the output register. One word is in work at a time,
// and s_ready is high only between words.
// The output register holds a finished word while m_ready is low; the
// next word is taken meanwhile and waits at the end of its work.
// Reset (aresetn low, synchronous) clears the registers, the elapsed
// count, the level and the output valid.
module eased_tween_interpolator (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_addr,
    input  logic [23:0]        cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_kind,
    input  logic [15:0]        s_delta_ticks,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [17:0] m_current_value,
    output logic [16:0]        m_progress,
    output logic               m_complete
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DSETUP = 9'b000000010,
        S_DIV    = 9'b000000100,
        S_EASE   = 9'b000001000,
        S_EWAIT  = 9'b000010000,
        S_COMB   = 9'b000100000,
        S_LVL    = 9'b001000000,
        S_LWAIT  = 9'b010000000,
        S_DONE   = 9'b100000000
    } state_t;

    localparam etw_pkg::prod_t ONE_P  = etw_pkg::prod_t'(etw_pkg::ONE);
    localparam etw_pkg::prod_t TWO_P  = etw_pkg::prod_t'(2 * etw_pkg::ONE);
    localparam etw_pkg::prod_t FOUR_P = etw_pkg::prod_t'(4 * etw_pkg::ONE);
    localparam etw_pkg::prod_t C1_P   = etw_pkg::prod_t'(etw_pkg::C1);
    localparam etw_pkg::prod_t C2_P   = etw_pkg::prod_t'(etw_pkg::C2);
    localparam etw_pkg::prod_t C3_P   = etw_pkg::prod_t'(etw_pkg::C3);
    localparam etw_pkg::prod_t C2P1_P = etw_pkg::prod_t'(etw_pkg::C2 + etw_pkg::ONE);
    localparam logic [24:0]    ELAPSED_MAX = 25'h1FFFFFF;
    localparam logic [16:0]    ONE_U = 17'(etw_pkg::ONE);

    state_t                 state_reg;
    logic signed [15:0]     start_reg;
    logic signed [15:0]     end_reg;
    logic [23:0]            dur_reg;
    logic [3:0]             mode_reg;
    logic [24:0]            elapsed_reg;
    logic signed [17:0]     level_reg;
    logic                   upd_reg;
    logic [16:0]            t_reg;
    logic [23:0]            rem_reg;
    logic [15:0]            quo_reg;
    logic [3:0]             div_cnt_reg;
    logic [2:0]             step_reg;
    etw_pkg::prod_t         p_reg [4];
    etw_pkg::prod_t         eased_reg;
    logic                   m_valid_reg;
    logic signed [17:0]     out_value_reg;
    logic [16:0]            out_prog_reg;
    logic                   out_cmpl_reg;

    logic                   cmpl;
    logic                   in_fire;
    logic [25:0]            elapsed_sum;
    logic [24:0]            div_sh;
    logic                   div_ge;
    logic                   half;
    logic [2:0]             nsteps;

    logic                   mul_start;
    etw_pkg::mop_t          mul_a;
    etw_pkg::mop_t          mul_b;
    logic                   mul_done;
    etw_pkg::prod_t         mul_product;

    etw_pkg::prod_t         ease_a;
    etw_pkg::prod_t         ease_b;
    etw_pkg::prod_t         eased_c;
    logic signed [16:0]     span;
    logic signed [33:0]     lvl_sum;

    logic [19:0]            expo_a;
    logic [16:0]            expo_g;
    logic [etw_pkg::POW_IDX_W-1:0] expo_k;
    logic [etw_pkg::POW_W-1:0]     expo_lo;
    logic [17:0]            expo_hi;
    logic [17:0]            expo_d;
    logic [15:0]            expo_m;
    logic [17:0]            expo_v;
    logic [3:0]             expo_s;
    logic [18:0]            expo_rnd;
    logic [17:0]            expo_pw;

    function automatic etw_pkg::prod_t round_half(input etw_pkg::prod_t v);
        etw_pkg::prod_t r;
        if (v >= 0) begin
            r = (v + 1) >>> 1;
        end else begin
            r = -((-v + 1) >>> 1);
        end
        return r;
    endfunction

    assign cmpl    = (dur_reg == '0) || (elapsed_reg >= {1'b0, dur_reg});
    assign s_ready = (state_reg == S_IDLE);
    assign in_fire = s_valid && s_ready;
    assign elapsed_sum = {1'b0, elapsed_reg} + 26'(s_delta_ticks);
    assign div_sh  = {rem_reg, 1'b0};
    assign div_ge  = div_sh >= {1'b0, dur_reg};
    assign half    = (t_reg[16:15] == 2'b00);
    assign span    = 17'(end_reg) - 17'(start_reg);
    assign lvl_sum = 34'(start_reg) + 34'(mul_product);

    always_comb begin
        unique case (mode_reg) inside
            etw_pkg::MODE_IN_QUAD, etw_pkg::MODE_OUT_QUAD, etw_pkg::MODE_INOUT_QUAD,
            etw_pkg::MODE_IN_EXPO, etw_pkg::MODE_OUT_EXPO,
            etw_pkg::MODE_INOUT_EXPO:                           nsteps = 3'd1;
            etw_pkg::MODE_IN_CUBIC, etw_pkg::MODE_OUT_CUBIC,
            etw_pkg::MODE_INOUT_CUBIC:                          nsteps = 3'd2;
            etw_pkg::MODE_INOUT_BACK:                           nsteps = 3'd3;
            etw_pkg::MODE_IN_BACK, etw_pkg::MODE_OUT_BACK:      nsteps = 3'd4;
            default:                                            nsteps = 3'd0;
        endcase
    end

    // power of two for the expo curves: 2^-a with a table and one multiply
    always_comb begin
        case (mode_reg)
            etw_pkg::MODE_IN_EXPO:  expo_a = 20'(10 * etw_pkg::ONE) - 20'(t_reg) * 20'd10;
            etw_pkg::MODE_OUT_EXPO: expo_a = 20'(t_reg) * 20'd10;
            default: begin
                if (half) begin
                    expo_a = 20'(10 * etw_pkg::ONE) - 20'(t_reg) * 20'd20;
                end else begin
                    expo_a = 20'(t_reg) * 20'd20 - 20'(10 * etw_pkg::ONE);
                end
            end
        endcase
        expo_g  = ONE_U - 17'(expo_a[15:0]);
        expo_k  = expo_g[15 -: etw_pkg::POW_IDX_W];
        expo_lo = etw_pkg::pow_entry(expo_k);
        expo_hi = (expo_k == '1) ? 18'(2 * etw_pkg::ONE)
                                 : 18'(etw_pkg::pow_entry(expo_k + 1'b1));
        expo_d  = expo_hi - 18'(expo_lo);
        expo_m  = {expo_g[15-etw_pkg::POW_IDX_W:0], etw_pkg::POW_IDX_W'(0)};
        if (expo_a[15:0] == '0) begin
            expo_v = 18'(etw_pkg::ONE);
            expo_s = expo_a[19:16];
        end else begin
            expo_v = 18'(expo_lo) + p_reg[0][17:0];
            expo_s = expo_a[19:16] + 1'b1;
        end
        expo_rnd = 19'(expo_v) + ((19'(1) << expo_s) >> 1);
        expo_pw  = (expo_s == '0) ? expo_v : 18'(expo_rnd >> expo_s);
    end

    always_comb begin
        etw_pkg::prod_t tw;
        etw_pkg::prod_t fw;
        etw_pkg::prod_t uw;
        etw_pkg::prod_t bw;
        tw = etw_pkg::prod_t'(t_reg);
        fw = tw - ONE_P;
        uw = half ? (tw <<< 1) : ((tw <<< 1) - TWO_P);
        bw = (mode_reg == etw_pkg::MODE_IN_BACK) ? tw : fw;
        ease_a = tw;
        ease_b = tw;
        unique case (mode_reg) inside
            etw_pkg::MODE_OUT_QUAD: ease_b = TWO_P - tw;
            etw_pkg::MODE_INOUT_QUAD: begin
                if (!half) ease_a = FOUR_P - (tw <<< 1);
            end
            etw_pkg::MODE_IN_CUBIC: begin
                if (step_reg != 3'd0) ease_a = p_reg[0];
            end
            etw_pkg::MODE_OUT_CUBIC: begin
                ease_a = (step_reg != 3'd0) ? p_reg[0] : fw;
                ease_b = fw;
            end
            etw_pkg::MODE_INOUT_CUBIC: begin
                if (half) begin
                    if (step_reg != 3'd0) ease_a = p_reg[0];
                end else begin
                    ease_a = (step_reg != 3'd0) ? p_reg[0] : fw;
                    ease_b = uw;
                end
            end
            etw_pkg::MODE_IN_EXPO, etw_pkg::MODE_OUT_EXPO, etw_pkg::MODE_INOUT_EXPO: begin
                ease_a = etw_pkg::prod_t'(expo_d);
                ease_b = etw_pkg::prod_t'(expo_m);
            end
            etw_pkg::MODE_IN_BACK, etw_pkg::MODE_OUT_BACK: begin
                case (step_reg)
                    3'd0: begin ease_a = bw;      ease_b = bw;      end
                    3'd1: begin ease_a = p_reg[0]; ease_b = bw;     end
                    3'd2: begin ease_a = C3_P;    ease_b = p_reg[1]; end
                    default: begin ease_a = C1_P; ease_b = p_reg[0]; end
                endcase
            end
            etw_pkg::MODE_INOUT_BACK: begin
                case (step_reg)
                    3'd0: begin ease_a = uw;      ease_b = uw; end
                    3'd1: begin ease_a = C2P1_P;  ease_b = uw; end
                    default: begin
                        ease_a = p_reg[0];
                        ease_b = half ? (p_reg[1] - C2_P) : (p_reg[1] + C2_P);
                    end
                endcase
            end
            default: begin
                ease_a = tw;
                ease_b = tw;
            end
        endcase
    end

    always_comb begin
        etw_pkg::prod_t tw;
        etw_pkg::prod_t pw;
        tw = etw_pkg::prod_t'(t_reg);
        pw = etw_pkg::prod_t'(expo_pw);
        unique case (mode_reg) inside
            etw_pkg::MODE_IN_QUAD, etw_pkg::MODE_OUT_QUAD:  eased_c = p_reg[0];
            etw_pkg::MODE_INOUT_QUAD:
                eased_c = half ? (p_reg[0] <<< 1) : (p_reg[0] - ONE_P);
            etw_pkg::MODE_IN_CUBIC:                         eased_c = p_reg[1];
            etw_pkg::MODE_OUT_CUBIC:                        eased_c = p_reg[1] + ONE_P;
            etw_pkg::MODE_INOUT_CUBIC:
                eased_c = half ? (p_reg[1] <<< 2) : (p_reg[1] + ONE_P);
            etw_pkg::MODE_IN_EXPO:
                eased_c = (t_reg == '0) ? '0 : pw;
            etw_pkg::MODE_OUT_EXPO:
                eased_c = (t_reg == ONE_U) ? ONE_P : (ONE_P - pw);
            etw_pkg::MODE_INOUT_EXPO: begin
                if (t_reg == '0) begin
                    eased_c = '0;
                end else if (t_reg == ONE_U) begin
                    eased_c = ONE_P;
                end else if (half) begin
                    eased_c = round_half(pw);
                end else begin
                    eased_c = ONE_P - round_half(pw);
                end
            end
            etw_pkg::MODE_IN_BACK:    eased_c = p_reg[2] - p_reg[3];
            etw_pkg::MODE_OUT_BACK:   eased_c = ONE_P + p_reg[2] + p_reg[3];
            etw_pkg::MODE_INOUT_BACK:
                eased_c = half ? round_half(p_reg[2]) : round_half(p_reg[2] + TWO_P);
            default:                  eased_c = tw;
        endcase
    end

    always_comb begin
        mul_start = (state_reg == S_LVL) ||
                    ((state_reg == S_EASE) && (step_reg != nsteps));
        if (state_reg == S_LVL) begin
            mul_a = etw_pkg::mop_t'(span);
            mul_b = eased_reg[etw_pkg::MUL_W-1:0];
        end else begin
            mul_a = ease_a[etw_pkg::MUL_W-1:0];
            mul_b = ease_b[etw_pkg::MUL_W-1:0];
        end
    end

    etw_serial_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .product (mul_product)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= '0;
            end_reg   <= '0;
            dur_reg   <= '0;
            mode_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                etw_pkg::REG_START:    start_reg <= cfg_wr_data[15:0];
                etw_pkg::REG_END:      end_reg   <= cfg_wr_data[15:0];
                etw_pkg::REG_DURATION: dur_reg   <= cfg_wr_data;
                etw_pkg::REG_MODE:     mode_reg  <= cfg_wr_data[3:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            elapsed_reg <= '0;
            level_reg   <= '0;
            upd_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != S_DONE)) m_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (in_fire) begin
                        upd_reg   <= (s_kind == etw_pkg::KIND_TICK) && !cmpl;
                        state_reg <= S_DSETUP;
                        case (s_kind)
                            etw_pkg::KIND_TICK: begin
                                if (!cmpl) begin
                                    elapsed_reg <= elapsed_sum[25] ? ELAPSED_MAX
                                                                   : elapsed_sum[24:0];
                                end
                            end
                            etw_pkg::KIND_RESTART: begin
                                elapsed_reg <= '0;
                                level_reg   <= 18'(start_reg);
                            end
                            etw_pkg::KIND_FINISH: begin
                                elapsed_reg <= {1'b0, dur_reg};
                                level_reg   <= 18'(end_reg);
                            end
                            default: ;
                        endcase
                    end
                end
                S_DSETUP: begin
                    if (cmpl) begin
                        state_reg <= upd_reg ? S_EASE : S_DONE;
                    end else begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_cnt_reg == 4'd15) state_reg <= upd_reg ? S_EASE : S_DONE;
                end
                S_EASE: begin
                    state_reg <= (step_reg == nsteps) ? S_COMB : S_EWAIT;
                end
                S_EWAIT: begin
                    if (mul_done) state_reg <= S_EASE;
                end
                S_COMB: state_reg <= S_LVL;
                S_LVL:  state_reg <= S_LWAIT;
                S_LWAIT: begin
                    if (mul_done) begin
                        if (lvl_sum > 34'sd131071) begin
                            level_reg <= 18'sh1FFFF;
                        end else if (lvl_sum < -34'sd131072) begin
                            level_reg <= 18'sh20000;
                        end else begin
                            level_reg <= lvl_sum[17:0];
                        end
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_DSETUP) begin
            rem_reg     <= elapsed_reg[23:0];
            quo_reg     <= '0;
            div_cnt_reg <= '0;
            step_reg    <= '0;
            if (cmpl) t_reg <= ONE_U;
        end
        if (state_reg == S_DIV) begin
            rem_reg     <= div_ge ? 24'(div_sh - {1'b0, dur_reg}) : div_sh[23:0];
            quo_reg     <= {quo_reg[14:0], div_ge};
            div_cnt_reg <= div_cnt_reg + 1'b1;
            if (div_cnt_reg == 4'd15) t_reg <= {1'b0, quo_reg[14:0], div_ge};
        end
        if ((state_reg == S_EWAIT) && mul_done) begin
            p_reg[step_reg[1:0]] <= mul_product;
            step_reg             <= step_reg + 1'b1;
        end
        if (state_reg == S_COMB) eased_reg <= eased_c;
        if ((state_reg == S_DONE) && (!m_valid_reg || m_ready)) begin
            out_value_reg <= level_reg;
            out_prog_reg  <= t_reg;
            out_cmpl_reg  <= cmpl;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_current_value = out_value_reg;
    assign m_progress      = out_prog_reg;
    assign m_complete      = out_cmpl_reg;

    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> !s_ready)
        else $error("second word taken while one is in work");

    a_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> (state_reg == S_EWAIT || state_reg == S_LWAIT))
        else $error("multiply finished outside a wait state");

    a_progress_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_progress <= ONE_U))
        else $error("progress above one");

    a_complete_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_complete == (m_progress == ONE_U)))
        else $error("complete flag disagrees with progress");

endmodule

// ===== rtl/etw_serial_mul.sv =====
module etw_serial_mul (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  etw_pkg::mop_t  op_a,
    input  etw_pkg::mop_t  op_b,
    output logic           done,
    output etw_pkg::prod_t product
);

    localparam int CNT_W = $clog2(etw_pkg::MUL_W);

    logic                       busy_reg;
    logic                       done_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [etw_pkg::MUL_W-1:0]  mag_a_reg;
    logic [etw_pkg::MUL_W-1:0]  hi_reg;
    logic [etw_pkg::MUL_W-1:0]  lo_reg;
    logic                       neg_reg;

    logic [etw_pkg::MUL_W:0]          sum;
    logic [2*etw_pkg::MUL_W:0]        rounded;
    logic [etw_pkg::PROD_W-1:0]       mag_res;

    // one multiplier bit per cycle, accumulator shifts right
    assign sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mag_a_reg} : '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(etw_pkg::MUL_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mag_a_reg <= op_a[etw_pkg::MUL_W-1] ? (~op_a + 1'b1) : op_a;
            lo_reg    <= op_b[etw_pkg::MUL_W-1] ? (~op_b + 1'b1) : op_b;
            hi_reg    <= '0;
            neg_reg   <= op_a[etw_pkg::MUL_W-1] ^ op_b[etw_pkg::MUL_W-1];
        end else if (busy_reg) begin
            hi_reg <= sum[etw_pkg::MUL_W:1];
            lo_reg <= {sum[0], lo_reg[etw_pkg::MUL_W-1:1]};
        end
    end

    // round to nearest, ties away from zero, on the magnitude
    assign rounded = {1'b0, hi_reg, lo_reg} + ((2*etw_pkg::MUL_W+1)'(1) << (etw_pkg::FRAC_BITS - 1));
    assign mag_res = etw_pkg::PROD_W'(rounded >> etw_pkg::FRAC_BITS);
    assign product = neg_reg ? -$signed(mag_res) : $signed(mag_res);
    assign done    = done_reg;

endmodule
